// ----- rtl/core/mws_pkg.sv -----
// ----------------------------------------------------------------------------
// mws_pkg: shared types, constants and shaping tables
// Holds the mode codes, the control and status structs and the tanh and sine
// tables built at elaboration from integer series in Q30.
// ----------------------------------------------------------------------------
package mws_pkg;

  localparam int TableAddrBits = 10;
  localparam int TabN          = 1 << TableAddrBits;
  localparam int HalfN         = 1 << (TableAddrBits - 1);
  localparam int QuarterN      = 1 << (TableAddrBits - 2);
  localparam int SampleWidth   = 16;
  localparam int Frac          = SampleWidth - 1;
  localparam int PhBits        = Frac + 10;
  localparam int TanhShift     = Frac + 11 - TableAddrBits;
  localparam int RomWidth      = 18;
  localparam int OpWidth       = 24;
  localparam int ProdWidth     = OpWidth + 17;
  localparam int CountWidth    = 14;

  localparam logic [2:0] MODE_SOFT  = 3'd0;
  localparam logic [2:0] MODE_HARD  = 3'd1;
  localparam logic [2:0] MODE_LFOLD = 3'd2;
  localparam logic [2:0] MODE_SFOLD = 3'd3;
  localparam logic [2:0] MODE_CRUSH = 3'd4;
  localparam logic [2:0] MODE_DOWN  = 3'd5;

  localparam logic [4:0] ADDR_MODE  = 5'd0;
  localparam logic [4:0] ADDR_DRIVE = 5'd4;
  localparam logic [4:0] ADDR_OGAIN = 5'd8;
  localparam logic [4:0] ADDR_CHALF = 5'd12;
  localparam logic [4:0] ADDR_CSTEP = 5'd16;
  localparam logic [4:0] ADDR_HOLD  = 5'd20;

  typedef logic signed [RomWidth-1:0] rom_t [TabN];

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] drive_gain;
    logic [15:0] output_gain;
    logic [12:0] crush_half_levels;
    logic [15:0] crush_step;
    logic [9:0]  hold_period;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul_in;
    logic shape;
    logic mul_n;
    logic sel;
    logic mul_out;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;

  localparam longint One30 = longint'(1) << 30;
  localparam longint PiQ30 = 64'sd3373259426;

  // elaboration-time truncating division by shift and subtract
  function automatic longint cdiv(longint num, longint den);
    longint q, r, a, b;
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((a >>> i) & longint'(1));
      q = q <<< 1;
      if (r >= b) begin
        r = r - b;
        q = q | longint'(1);
      end
    end
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic rom_t build_tanh();
    rom_t   tab;
    longint term, sum, t;
    for (int k = 0; k < TabN; k++) begin
      term = One30;
      sum  = One30;
      for (int n = 1; n <= 14; n++) begin
        term = cdiv((term * (longint'(k) << (30 - TableAddrBits))) >>> 30, longint'(n));
        sum  = ((n & 1) == 1) ? sum - term : sum + term;
      end
      t = sum;
      for (int i = 0; i < 4; i++) t = (t * t + (One30 >>> 1)) >>> 30;
      tab[k] = RomWidth'(cdiv(((One30 - t) <<< Frac) + ((One30 + t) >>> 1), One30 + t));
    end
    return tab;
  endfunction

  function automatic rom_t build_sine();
    rom_t   tab;
    longint x, x2, term, sum, e;
    int     m, j;
    for (int k = 0; k < TabN; k++) begin
      m = (k >= HalfN) ? k - HalfN : k;
      j = (m <= QuarterN) ? m : HalfN - m;
      x = (2 * PiQ30 * longint'(j) + longint'(HalfN)) >>> TableAddrBits;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = cdiv((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
        sum  = ((n & 1) == 1) ? sum - term : sum + term;
      end
      e = (sum + (longint'(1) << (29 - Frac))) >>> (30 - Frac);
      tab[k] = RomWidth'((k >= HalfN) ? -e : e);
    end
    return tab;
  endfunction

  localparam rom_t TANH_TAB = build_tanh();
  localparam rom_t SINE_TAB = build_sine();

endpackage

// ----- rtl/core/mws_ctrl.sv -----
// ----------------------------------------------------------------------------
// mws_ctrl: sequencing controller
// Steps one sample through the shared multiplier and shaping stages.
// ----------------------------------------------------------------------------
module mws_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  mws_pkg::status_t status,
  output mws_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_IN  = 3'd1;
  localparam logic [2:0] ST_SHAPE   = 3'd2;
  localparam logic [2:0] ST_MUL_N   = 3'd3;
  localparam logic [2:0] ST_SEL     = 3'd4;
  localparam logic [2:0] ST_MUL_OUT = 3'd5;
  localparam logic [2:0] ST_FIN     = 3'd6;

  logic [2:0] state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.load    = s_tready && s_tvalid;
    cmd.mul_in  = (state == ST_MUL_IN);
    cmd.shape   = (state == ST_SHAPE);
    cmd.mul_n   = (state == ST_MUL_N);
    cmd.sel     = (state == ST_SEL);
    cmd.mul_out = (state == ST_MUL_OUT);
    cmd.fin     = (state == ST_FIN) && !status.out_blocked;
    case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_MUL_IN;
      ST_MUL_IN:  state_next = ST_SHAPE;
      ST_SHAPE:   state_next = ST_MUL_N;
      ST_MUL_N:   state_next = ST_SEL;
      ST_SEL:     state_next = ST_MUL_OUT;
      ST_MUL_OUT: state_next = ST_FIN;
      ST_FIN:     if (!status.out_blocked) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/mws_dp.sv -----
// ----------------------------------------------------------------------------
// mws_dp: shaping datapath
// Shared signed multiplier, tables, hold counter and the output register.
// ----------------------------------------------------------------------------
module mws_dp (
  input  logic             clk,
  input  logic             rst,
  input  mws_pkg::cfg_t    cfg,
  input  mws_pkg::cmd_t    cmd,
  output mws_pkg::status_t status,
  input  logic [15:0]      s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata
);

  localparam int PW = mws_pkg::ProdWidth;
  localparam int OW = mws_pkg::OpWidth;
  localparam int AB = mws_pkg::TableAddrBits;
  localparam int PB = mws_pkg::PhBits;

  localparam mws_pkg::rom_t TanhRom = mws_pkg::TANH_TAB;
  localparam mws_pkg::rom_t SineRom = mws_pkg::SINE_TAB;

  logic signed [15:0]   x;
  logic signed [PW-1:0] prod;
  logic signed [OW-1:0] s_reg;
  logic signed [7:0]    n_reg;
  logic signed [mws_pkg::RomWidth-1:0] tanh_q, sine_q;
  logic                 neg_flag, tanh_sat;
  logic [mws_pkg::CountWidth-1:0] hold_count;
  logic [15:0]          held_sample;

  // shared multiplier operands
  logic signed [OW-1:0] op_a;
  logic [15:0]          op_b;
  logic signed [PW-1:0] mul_res;

  always_comb begin
    op_a = OW'(x);
    op_b = cfg.drive_gain;
    if (cmd.mul_in && cfg.mode == mws_pkg::MODE_CRUSH) begin
      op_b = {3'b0, cfg.crush_half_levels};
    end else if (cmd.mul_n) begin
      op_a = OW'(n_reg);
      op_b = cfg.crush_step;
    end else if (cmd.mul_out) begin
      op_a = s_reg;
      op_b = cfg.output_gain;
    end
  end

  assign mul_res = PW'(op_a * $signed({1'b0, op_b}));

  // shaping from the driven product
  logic                  p_neg;
  logic [PW-1:0]         mag;
  logic [PB-1:0]         ph_lin, ph_sin;
  logic signed [PB+3:0]  d, d_abs;
  logic signed [PW-1:0]  clamped;
  logic signed [OW-1:0]  s_hard, s_lin;
  logic [7:0]            n_mag;
  logic [9:0]            period;
  logic [mws_pkg::CountWidth-1:0] cnt_inc;

  always_comb begin
    p_neg   = prod[PW-1];
    mag     = p_neg ? PW'(-prod) : PW'(prod);
    ph_lin  = PB'(prod) + PB'(3 << (PB - 2));
    ph_sin  = PB'(1 << (PB - 1)) - PB'(prod);
    d       = (PB+4)'(2 << PB) - (PB+4)'({ph_lin, 2'b00});
    d_abs   = d[PB+3] ? -d : d;
    s_lin   = OW'((d_abs - (PB+4)'(1 << PB)) >>> (PB - mws_pkg::Frac));
    clamped = prod;
    if (prod > PW'(1 << (mws_pkg::Frac + 8))) clamped = PW'(1 << (mws_pkg::Frac + 8));
    if (prod < -PW'(1 << (mws_pkg::Frac + 8))) clamped = -PW'(1 << (mws_pkg::Frac + 8));
    s_hard  = OW'(clamped >>> 8);
    n_mag   = 8'((mag + PW'(1 << (mws_pkg::Frac + 7))) >> (mws_pkg::Frac + 8));
    period  = (cfg.hold_period < 10'd16) ? 10'd16 : cfg.hold_period;
    cnt_inc = hold_count + mws_pkg::CountWidth'(16);
  end

  // output rounding and saturation
  logic signed [PW-1:0] y_full;
  logic [15:0]          y_sat;

  always_comb begin
    y_full = (prod + PW'(128)) >>> 8;
    if (y_full > PW'(32767)) y_sat = 16'h7fff;
    else if (y_full < -PW'(32768)) y_sat = 16'h8000;
    else y_sat = y_full[15:0];
  end

  assign status.out_blocked = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) x <= $signed(s_tdata);
    if (cmd.mul_in || cmd.mul_n || cmd.mul_out) prod <= mul_res;
    if (cmd.shape) begin
      // table reads, registered
      tanh_q   <= TanhRom[mag[mws_pkg::TanhShift +: AB]];
      sine_q   <= SineRom[ph_sin[PB-1 -: AB]];
      tanh_sat <= (mag >> (mws_pkg::TanhShift + AB)) != '0;
      neg_flag <= p_neg;
      n_reg    <= p_neg ? -$signed(n_mag) : $signed(n_mag);
      case (cfg.mode)
        mws_pkg::MODE_HARD:  s_reg <= s_hard;
        mws_pkg::MODE_LFOLD: s_reg <= s_lin;
        default:             s_reg <= s_reg;
      endcase
    end
    if (cmd.mul_n) begin
      if (cfg.mode == mws_pkg::MODE_SOFT) begin
        if (tanh_sat) s_reg <= neg_flag ? -OW'(1 << mws_pkg::Frac) : OW'(1 << mws_pkg::Frac);
        else s_reg <= neg_flag ? -OW'(tanh_q) : OW'(tanh_q);
      end else if (cfg.mode == mws_pkg::MODE_SFOLD) begin
        s_reg <= OW'(sine_q);
      end else if (cfg.mode == mws_pkg::MODE_DOWN) begin
        s_reg <= OW'($signed(held_sample));
      end
    end
    if (cmd.sel && cfg.mode == mws_pkg::MODE_CRUSH) s_reg <= OW'(prod);
    if (cmd.fin) m_tdata <= (cfg.mode > mws_pkg::MODE_DOWN) ? x : y_sat;
  end

  // hold counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count  <= '0;
      held_sample <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.shape && cfg.mode == mws_pkg::MODE_DOWN) begin
        if (cnt_inc >= mws_pkg::CountWidth'(period)) begin
          hold_count  <= cnt_inc - mws_pkg::CountWidth'(period);
          held_sample <= x;
        end else begin
          hold_count <= cnt_inc;
        end
      end
      if (cmd.fin) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/multimode_waveshaper_unit.sv -----
// ----------------------------------------------------------------------------
// multimode_waveshaper_unit: six-mode audio waveshaper, one channel
// Register file, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry input words (in_sample, signed Q1.15).
//   m_tvalid/m_tready/m_tdata carry shaped words (out_sample, Q1.15).
//   The apb port writes mode, drive_gain, output_gain, crush_half_levels,
//   crush_step and hold_period at byte addresses 0,4,8,12,16,20.
// Timing:
//   a word steps through the mul_in, shape, mul_n, sel, mul_out and fin
//   states after acceptance; s_tready rises with m_tvalid, so the next word
//   is taken once the last is done. The pace is set by the single shared
//   multiplier, used three times per word, and the registered table read.
//   A finished word waits in the output register while the next input word
//   is accepted and processed; if the receiver still stalls, the controller
//   holds in its last step until the output register frees up.
// Reset:
//   rst clears the controller, output valid, hold counter and held sample,
//   and returns the registers to their defaults. Tables are constant.
// ----------------------------------------------------------------------------
module multimode_waveshaper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] in_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] out_sample
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mws_pkg::cfg_t    cfg;
  mws_pkg::cmd_t    cmd;
  mws_pkg::status_t status;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= mws_pkg::MODE_SOFT;
      cfg.drive_gain        <= 16'd256;
      cfg.output_gain       <= 16'd256;
      cfg.crush_half_levels <= 13'd256;
      cfg.crush_step        <= 16'hffff;
      cfg.hold_period       <= 10'd16;
    end else if (wr_en) begin
      case (paddr)
        mws_pkg::ADDR_MODE:  cfg.mode              <= pwdata[2:0];
        mws_pkg::ADDR_DRIVE: cfg.drive_gain        <= pwdata[15:0];
        mws_pkg::ADDR_OGAIN: cfg.output_gain       <= pwdata[15:0];
        mws_pkg::ADDR_CHALF: cfg.crush_half_levels <= pwdata[12:0];
        mws_pkg::ADDR_CSTEP: cfg.crush_step        <= pwdata[15:0];
        mws_pkg::ADDR_HOLD:  cfg.hold_period       <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      mws_pkg::ADDR_MODE:  prdata = {29'b0, cfg.mode};
      mws_pkg::ADDR_DRIVE: prdata = {16'b0, cfg.drive_gain};
      mws_pkg::ADDR_OGAIN: prdata = {16'b0, cfg.output_gain};
      mws_pkg::ADDR_CHALF: prdata = {19'b0, cfg.crush_half_levels};
      mws_pkg::ADDR_CSTEP: prdata = {16'b0, cfg.crush_step};
      mws_pkg::ADDR_HOLD:  prdata = {22'b0, cfg.hold_period};
      default:             prdata = 32'b0;
    endcase
  end

  mws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mws_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/core/mws_checker.sv -----
// ----------------------------------------------------------------------------
// mws_checker: port-level checks
// Watches the stream ports of the waveshaper over time.
// ----------------------------------------------------------------------------
module mws_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // output register empties on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // one word in flight: input closes after an accepted word
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still open after accept");

  // no result can appear right after an accept
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("result too early");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output changed");

endmodule

bind multimode_waveshaper_unit mws_checker u_mws_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_multimode_waveshaper_unit.sv -----
// ----------------------------------------------------------------------------
// tb_multimode_waveshaper_unit: self-checking bench for the waveshaper
// Drives samples over the stream port in every shaping mode and over a range
// of gain, crush and hold settings, predicts each shaped word in the bench
// and compares it with the block's output under varied idle and stall rates.
// ----------------------------------------------------------------------------
module tb_multimode_waveshaper_unit;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] in_sample
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [15:0] out_sample
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  multimode_waveshaper_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the register file and shaping state
  logic [2:0]  sh_mode;
  logic [15:0] sh_drive;
  logic [15:0] sh_ogain;
  logic [12:0] sh_chalf;
  logic [15:0] sh_cstep;
  logic [9:0]  sh_hold;
  logic [13:0] sh_count;
  logic [15:0] sh_held;

  logic [15:0] shaped_q[$];
  int          errors;
  int          cycles;
  int          send_idle;
  int          recv_stall;
  logic [31:0] tanh_tab[mws_pkg::TabN];
  logic [31:0] sine_tab[mws_pkg::TabN];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // tables rebuilt independently with the same Q30 series
  task automatic build_shape_tables();
    longint term, sum, t, x, x2, e, one30;
    int     m, j, tab_n, frac;
    one30 = mws_pkg::One30;
    tab_n = mws_pkg::TabN;
    frac  = mws_pkg::Frac;
    for (int k = 0; k < tab_n; k++) begin
      term = one30;
      sum  = one30;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * (longint'(k) << (30 - mws_pkg::TableAddrBits))) >>> 30) / n;
        sum  = (n % 2) ? sum - term : sum + term;
      end
      t = sum;
      for (int i = 0; i < 4; i++) t = (t * t + (one30 >>> 1)) >>> 30;
      tanh_tab[k] = 32'((((one30 - t) <<< frac) + ((one30 + t) >>> 1)) / (one30 + t));
      m = (k >= tab_n / 2) ? k - tab_n / 2 : k;
      j = (m <= tab_n / 4) ? m : tab_n / 2 - m;
      x = (2 * mws_pkg::PiQ30 * longint'(j) + longint'(tab_n / 2)) / longint'(tab_n);
      x2 = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
        sum  = (n % 2) ? sum - term : sum + term;
      end
      e = (sum + (longint'(1) << (29 - frac))) >>> (30 - frac);
      sine_tab[k] = 32'((k >= tab_n / 2) ? -e : e);
    end
  endtask

  function automatic logic [15:0] shape_sample(logic [15:0] raw);
    longint x, v, s, y, mag, d, q, n, val, lim;
    logic [24:0] ph;
    logic [13:0] period;
    x = longint'($signed(raw));
    v = x * longint'(sh_drive);
    case (sh_mode)
      mws_pkg::MODE_SOFT: begin
        mag = v < 0 ? -v : v;
        mag = mag >>> mws_pkg::TanhShift;
        s = mag >= mws_pkg::TabN ? (longint'(1) << mws_pkg::Frac)
                                 : longint'($signed(tanh_tab[mag]));
        if (v < 0) s = -s;
      end
      mws_pkg::MODE_HARD: begin
        lim = longint'(1) << (mws_pkg::Frac + 8);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        s = fshift(v, 8);
      end
      mws_pkg::MODE_LFOLD: begin
        ph = 25'(v + (longint'(3) << (mws_pkg::PhBits - 2)));
        d = (longint'(2) << mws_pkg::PhBits) - 4 * longint'(ph);
        if (d < 0) d = -d;
        s = fshift(d - (longint'(1) << mws_pkg::PhBits), mws_pkg::PhBits - mws_pkg::Frac);
      end
      mws_pkg::MODE_SFOLD: begin
        ph = 25'((longint'(1) << (mws_pkg::PhBits - 1)) - v);
        s = longint'($signed(sine_tab[ph >> (mws_pkg::PhBits - mws_pkg::TableAddrBits)]));
      end
      mws_pkg::MODE_CRUSH: begin
        q = x * longint'(sh_chalf);
        mag = q < 0 ? -q : q;
        n = (mag + (longint'(1) << (mws_pkg::Frac + 7))) >>> (mws_pkg::Frac + 8);
        if (q < 0) n = -n;
        val = n * longint'(sh_cstep);
        s = val;
      end
      mws_pkg::MODE_DOWN: begin
        period = sh_hold < 16 ? 14'd16 : 14'(sh_hold);
        sh_count = sh_count + 14'd16;
        if (sh_count >= period) begin
          sh_count = sh_count - period;
          sh_held = raw;
        end
        s = longint'($signed(sh_held));
      end
      default: return raw;
    endcase
    y = fshift(s * longint'(sh_ogain) + 128, 8);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (shaped_q.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 16'h0);
      end else begin
        if (m_tdata !== shaped_q[0]) report_mismatch("out_sample", m_tdata, shaped_q[0]);
        void'(shaped_q.pop_front());
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("tb_multimode_waveshaper_unit NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [4:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (addr)
      mws_pkg::ADDR_MODE:  sh_mode  = data[2:0];
      mws_pkg::ADDR_DRIVE: sh_drive = data[15:0];
      mws_pkg::ADDR_OGAIN: sh_ogain = data[15:0];
      mws_pkg::ADDR_CHALF: sh_chalf = data[12:0];
      mws_pkg::ADDR_CSTEP: sh_cstep = data[15:0];
      mws_pkg::ADDR_HOLD:  sh_hold  = data[9:0];
      default: ;
    endcase
  endtask

  // tvalid stays up between back-to-back words and drops on idle or drain
  task automatic send_word(logic [15:0] smp);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shaped_q.push_back(shape_sample(smp));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (shaped_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] edges[8];
    edges = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h4000, 16'hc000, 16'h5555};
    for (int m = 0; m < 8; m++) begin
      write_reg(mws_pkg::ADDR_MODE, 32'(m));
      foreach (edges[i]) if (i < 3 || m < 6) send_word(edges[i]);
      drain();
    end
  endtask

  task automatic test_mode_sweep(int count);
    for (int r = 0; r < count; r++) begin
      write_reg(mws_pkg::ADDR_MODE, 32'($urandom_range(7)));
      case ($urandom_range(3))
        0: write_reg(mws_pkg::ADDR_DRIVE, 32'hffff);
        1: write_reg(mws_pkg::ADDR_DRIVE, 32'h0000);
        default: write_reg(mws_pkg::ADDR_DRIVE, 32'($urandom));
      endcase
      write_reg(mws_pkg::ADDR_OGAIN,
                $urandom_range(3) == 0 ? 32'hffff : 32'($urandom_range(1024)));
      write_reg(mws_pkg::ADDR_CHALF,
                $urandom_range(3) == 0 ? 32'h1fff : 32'($urandom_range(4096, 128)));
      write_reg(mws_pkg::ADDR_CSTEP,
                $urandom_range(3) == 0 ? 32'h0 : 32'($urandom));
      write_reg(mws_pkg::ADDR_HOLD,
                $urandom_range(3) == 0 ? 32'h3ff : 32'($urandom_range(40)));
      repeat (25) send_word(rand_sample());
      drain();
    end
  endtask

  initial begin
    clk = 1'b0; rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; cycles = 0; send_idle = 0; recv_stall = 0;
    sh_mode = mws_pkg::MODE_SOFT; sh_drive = 16'd256; sh_ogain = 16'd256;
    sh_chalf = 13'd256; sh_cstep = 16'hffff; sh_hold = 10'd16;
    sh_count = '0; sh_held = '0;
    build_shape_tables();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle = 0;  recv_stall = 0;  test_mode_sweep(6);
    send_idle = 60; recv_stall = 0;  test_mode_sweep(6);
    send_idle = 0;  recv_stall = 60; test_mode_sweep(6);
    send_idle = 6;  recv_stall = 6;  test_mode_sweep(6);
    drain();
    if (errors == 0) begin
      $display("tb_multimode_waveshaper_unit OK");
    end else begin
      $display("tb_multimode_waveshaper_unit NOT OK");
    end
    $finish;
  end

endmodule
